### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the flight envelope block.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define FES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define FES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/fes_pkg.sv
// Package for the flight envelope statistics block: widths, codes, structs
// and clamp helpers. No dependencies.
`default_nettype none

package fes_pkg;

  localparam int MOTORS_DEF   = 4;
  localparam int NUM_ANGLES   = 5;
  localparam int IN_TDATA_W   = 328;
  localparam int OUT_TDATA_W  = 200;
  localparam int IN_FIELDS_W  = 321;
  localparam int OUT_FIELDS_W = 193;

  localparam logic [9:0]  MOTOR_DUTY_MAX = 10'd1000;
  localparam logic [15:0] BATT_NONE      = 16'hFFFF;
  localparam logic [14:0] ABS_SAT        = 15'h7FFF;

  // flight state codes
  localparam logic [1:0] FLIGHT_NONE   = 2'd0;
  localparam logic [1:0] FLIGHT_ENDED  = 2'd1;
  localparam logic [1:0] FLIGHT_ACTIVE = 2'd2;

  typedef struct packed {
    logic signed [31:0] yaw_out_milli;
    logic signed [31:0] pitch_out_milli;
    logic signed [31:0] roll_out_milli;
    logic signed [31:0] pitch_centideg;
    logic signed [31:0] roll_centideg;
    logic [63:0]        motor_duties;
    logic [15:0]        battery_mv;
    logic [15:0]        throttle_cmd;
    logic [15:0]        disarm_reason_flags;
    logic [15:0]        fs_flag_word;
    logic [31:0]        sample_time_ms;
    logic               armed;
  } sample_t;

  // per-sample derived values
  typedef struct packed {
    logic [NUM_ANGLES-1:0][14:0] abs_val;
    logic [9:0]                  motor_spread;
    logic [9:0]                  motor_max;
  } conv_t;

  typedef struct packed {
    logic [14:0] peak_yaw_out;
    logic [14:0] peak_pitch_out;
    logic [14:0] peak_roll_out;
    logic [14:0] peak_pitch;
    logic [14:0] peak_roll;
    logic [9:0]  peak_motor_spread;
    logic [9:0]  peak_motor;
    logic [15:0] peak_throttle;
    logic [15:0] min_battery_mv;
    logic [31:0] stop_and_disarm_flags;
    logic [31:0] flight_len_ms;
    logic [1:0]  flight_state;
  } result_t;

  // signed 16-bit duty clamped to 0..1000
  function automatic logic [9:0] motor_clamp(input logic [15:0] raw);
    logic [9:0] res;
    if (raw[15]) begin
      res = 10'd0;
    end else if (raw > {6'd0, MOTOR_DUTY_MAX}) begin
      res = MOTOR_DUTY_MAX;
    end else begin
      res = raw[9:0];
    end
    return res;
  endfunction

  // clamp to 16-bit signed, absolute value, -32768 saturates
  function automatic logic [14:0] abs_sat15(input logic signed [31:0] v);
    logic [14:0] res;
    logic signed [31:0] neg;
    neg = -v;
    if (v >= 32'sd32767) begin
      res = ABS_SAT;
    end else if (v <= -32'sd32767) begin
      res = ABS_SAT;
    end else if (v < 32'sd0) begin
      res = neg[14:0];
    end else begin
      res = v[14:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/flight_envelope_statistics.sv
// Flight envelope statistics, top level. Uses fes_pkg, fes_sample_conv, fes_record.
// Each request is held in the input register, then in the result register, which
// drives out_tvalid and out_tdata.
// Throughput: one request per cycle; only out_tready low stalls, and in_tready
// drops while both registers hold a request and out_tready is low.
// Reset (rst_n low, synchronous): pipeline empty, record cleared to no flight seen.
`default_nettype none

module flight_envelope_statistics #(
  parameter int MOTORS = fes_pkg::MOTORS_DEF  // motors in motor_duties, 2..4
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // in_tdata, from bit 0: armed, sample_time_ms[32], fs_flag_word[16],
  // disarm_reason_flags[16], throttle_cmd[16], battery_mv[16],
  // motor_duties[64], roll_centideg, pitch_centideg, roll_out_milli,
  // pitch_out_milli, yaw_out_milli [32 each], zero pad
  input  wire [fes_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // out_tdata, from bit 0: flight_state[2], flight_len_ms[32],
  // stop_and_disarm_flags[32], min_battery_mv[16], peak_throttle[16],
  // peak_motor[10], peak_motor_spread[10], peak_roll, peak_pitch,
  // peak_roll_out, peak_pitch_out, peak_yaw_out [15 each], zero pad
  output logic [fes_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready
);

  // input register stage
  logic             in_valid_r;
  fes_pkg::sample_t in_smp_r;
  // result register stage
  logic             out_valid_r;
  fes_pkg::result_t out_res_r;

  fes_pkg::conv_t   conv;
  fes_pkg::result_t res_nxt;
  logic             advance;
  logic             in_take;

  // the held request moves on whenever the result slot is free or draining
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_take   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_smp_r <= fes_pkg::sample_t'(in_tdata[fes_pkg::IN_FIELDS_W-1:0]);
    end
  end

  fes_sample_conv #(
    .MOTORS (MOTORS)
  ) u_conv (
    .smp  (in_smp_r),
    .conv (conv)
  );

  // record state updates only when a request is handed to the result stage
  fes_record u_record (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .smp     (in_smp_r),
    .conv    (conv),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(fes_pkg::OUT_TDATA_W - fes_pkg::OUT_FIELDS_W){1'b0}}, out_res_r};

endmodule

`default_nettype wire

### hw/rtl/fes_sample_conv.sv
// Per-sample conversion: motor duty clamp with max/spread, absolute
// saturated attitude and outputs. Uses fes_pkg.
`default_nettype none

module fes_sample_conv #(
  parameter int MOTORS = fes_pkg::MOTORS_DEF
) (
  input  wire fes_pkg::sample_t smp,
  output fes_pkg::conv_t        conv
);

  logic [9:0] duty [MOTORS];
  logic [9:0] mx;
  logic [9:0] mn;

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      duty[i] = fes_pkg::motor_clamp(smp.motor_duties[16*i +: 16]);
    end
  end

  // short min/max chain over at most four motors
  always_comb begin
    mx = duty[0];
    mn = duty[0];
    for (int i = 1; i < MOTORS; i++) begin
      if (duty[i] > mx) begin
        mx = duty[i];
      end
      if (duty[i] < mn) begin
        mn = duty[i];
      end
    end
  end

  always_comb begin
    conv.motor_max    = mx;
    conv.motor_spread = mx - mn;
    conv.abs_val[0]   = fes_pkg::abs_sat15(smp.roll_centideg);
    conv.abs_val[1]   = fes_pkg::abs_sat15(smp.pitch_centideg);
    conv.abs_val[2]   = fes_pkg::abs_sat15(smp.roll_out_milli);
    conv.abs_val[3]   = fes_pkg::abs_sat15(smp.pitch_out_milli);
    conv.abs_val[4]   = fes_pkg::abs_sat15(smp.yaw_out_milli);
  end

endmodule

`default_nettype wire

### hw/rtl/fes_record.sv
// Flight record: arm edge detection, record state and summary build.
// Uses fes_pkg; fed by fes_sample_conv.
`default_nettype none

module fes_record (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire fes_pkg::sample_t smp,
  input  wire fes_pkg::conv_t   conv,
  output fes_pkg::result_t      res_nxt
);

  logic        seen_r, seen_nxt;
  logic        active_r, active_nxt;
  logic        prev_armed_r;
  logic [31:0] start_r, start_nxt;
  logic [31:0] end_r, end_nxt;
  logic [15:0] stop_r, stop_nxt;
  logic [15:0] disarm_r, disarm_nxt;
  logic [15:0] batt_r, batt_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic [9:0]  motor_r, motor_nxt;
  logic [9:0]  spread_r, spread_nxt;
  logic [fes_pkg::NUM_ANGLES-1:0][14:0] peak_r, peak_nxt;

  logic rise, fall, upd;
  logic [15:0] b_batt, b_thr;
  logic [9:0]  b_motor, b_spread;
  logic [fes_pkg::NUM_ANGLES-1:0][14:0] b_peak;

  assign rise = smp.armed & ~prev_armed_r;
  assign fall = ~smp.armed & prev_armed_r;

  always_comb begin
    // a new record starts from cleared values
    b_batt   = rise ? fes_pkg::BATT_NONE : batt_r;
    b_thr    = rise ? 16'd0 : thr_r;
    b_motor  = rise ? 10'd0 : motor_r;
    b_spread = rise ? 10'd0 : spread_r;
    b_peak   = rise ? '0 : peak_r;

    seen_nxt   = seen_r | rise;
    active_nxt = fall ? 1'b0 : (rise ? 1'b1 : active_r);
    upd        = seen_nxt & (smp.armed | prev_armed_r);
    start_nxt  = rise ? smp.sample_time_ms : start_r;
    end_nxt    = (rise | upd | fall) ? smp.sample_time_ms : end_r;
    stop_nxt   = (upd | fall) ? smp.fs_flag_word
               : (rise ? 16'd0 : stop_r);
    disarm_nxt = (upd | fall) ? smp.disarm_reason_flags
               : (rise ? 16'd0 : disarm_r);

    batt_nxt   = b_batt;
    thr_nxt    = b_thr;
    motor_nxt  = b_motor;
    spread_nxt = b_spread;
    peak_nxt   = b_peak;
    if (upd) begin
      if (smp.battery_mv != 16'd0 && smp.battery_mv < b_batt) begin
        batt_nxt = smp.battery_mv;
      end
      if (smp.throttle_cmd > b_thr) begin
        thr_nxt = smp.throttle_cmd;
      end
      if (conv.motor_max > b_motor) begin
        motor_nxt = conv.motor_max;
      end
      if (conv.motor_spread > b_spread) begin
        spread_nxt = conv.motor_spread;
      end
      for (int i = 0; i < fes_pkg::NUM_ANGLES; i++) begin
        if (conv.abs_val[i] > b_peak[i]) begin
          peak_nxt[i] = conv.abs_val[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      active_r     <= 1'b0;
      prev_armed_r <= 1'b0;
      start_r      <= '0;
      end_r        <= '0;
      stop_r       <= '0;
      disarm_r     <= '0;
      batt_r       <= '0;
      thr_r        <= '0;
      motor_r      <= '0;
      spread_r     <= '0;
      peak_r       <= '0;
    end else if (en) begin
      seen_r       <= seen_nxt;
      active_r     <= active_nxt;
      prev_armed_r <= smp.armed;
      start_r      <= start_nxt;
      end_r        <= end_nxt;
      stop_r       <= stop_nxt;
      disarm_r     <= disarm_nxt;
      batt_r       <= batt_nxt;
      thr_r        <= thr_nxt;
      motor_r      <= motor_nxt;
      spread_r     <= spread_nxt;
      peak_r       <= peak_nxt;
    end
  end

  // summary from the updated record
  always_comb begin
    if (!seen_nxt) begin
      res_nxt.flight_state = fes_pkg::FLIGHT_NONE;
    end else if (active_nxt) begin
      res_nxt.flight_state = fes_pkg::FLIGHT_ACTIVE;
    end else begin
      res_nxt.flight_state = fes_pkg::FLIGHT_ENDED;
    end
    res_nxt.flight_len_ms = (end_nxt >= start_nxt) ? (end_nxt - start_nxt) : 32'd0;
    res_nxt.stop_and_disarm_flags = {stop_nxt, disarm_nxt};
    res_nxt.min_battery_mv    = (batt_nxt == fes_pkg::BATT_NONE) ? 16'd0 : batt_nxt;
    res_nxt.peak_throttle     = thr_nxt;
    res_nxt.peak_motor        = motor_nxt;
    res_nxt.peak_motor_spread = spread_nxt;
    res_nxt.peak_roll         = peak_nxt[0];
    res_nxt.peak_pitch        = peak_nxt[1];
    res_nxt.peak_roll_out     = peak_nxt[2];
    res_nxt.peak_pitch_out    = peak_nxt[3];
    res_nxt.peak_yaw_out      = peak_nxt[4];
  end

endmodule

`default_nettype wire

### hw/rtl/fes_checker.sv
// Port-level checker for flight_envelope_statistics, bound to the top level.
// Uses assert_macros.svh and fes_pkg.
`default_nettype none
`include "assert_macros.svh"

module fes_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [fes_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // stalled result holds
  `FES_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // reset empties the pipe and opens the input
  `FES_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && in_tready, "pipe not empty after reset")

  // with no flight seen the summary is all zero
  `FES_ASSERT(a_no_flight_zero, out_tvalid && out_tdata[1:0] == fes_pkg::FLIGHT_NONE |-> out_tdata[fes_pkg::OUT_TDATA_W-1:2] == '0, "summary not clear before first flight")

  // motor peak within the duty clamp
  `FES_ASSERT(a_motor_range, out_tvalid |-> out_tdata[107:98] <= fes_pkg::MOTOR_DUTY_MAX, "peak motor above clamp")

  // a spread never exceeds the largest duty
  `FES_ASSERT(a_spread_le_peak, out_tvalid |-> out_tdata[117:108] <= out_tdata[107:98], "spread above peak motor")

endmodule

bind flight_envelope_statistics fes_checker u_fes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### verif/fes_summary_checker.sv
`timescale 1ns / 1ps
// Scoreboard for flight_envelope_statistics: watches both stream channels, keeps its
// own copy of the flight record and compares each summary field by field. Uses fes_pkg.
module fes_summary_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [fes_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire                            in_tvalid,
  input  wire                            in_tready,
  input  wire [fes_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                            out_tvalid,
  input  wire                            out_tready,
  output int                             mismatch_count,
  output int                             summaries_due
);
  import fes_pkg::*;

  localparam int REPORT_MAX = 10;

  result_t     expected_summaries[$];
  int          errs;

  // shadow flight record
  logic        rec_seen;
  logic        rec_active;
  logic        was_armed;
  logic [31:0] rec_start;
  logic [31:0] rec_end;
  logic [15:0] rec_stop_flags;
  logic [15:0] rec_disarm_flags;
  logic [15:0] rec_batt_min;
  logic [15:0] rec_thr_max;
  logic [9:0]  rec_motor_max;
  logic [9:0]  rec_spread_max;
  logic [14:0] rec_peak [NUM_ANGLES];

  // signed 16-bit duty limited to 0..1000
  function automatic logic [9:0] clamp_duty(input logic [15:0] raw);
    int v;
    v = $signed(raw);
    if (v < 0) begin
      v = 0;
    end
    if (v > 1000) begin
      v = 1000;
    end
    return v[9:0];
  endfunction

  // limit to 16-bit signed, then magnitude; -32768 tops out at 32767
  function automatic logic [14:0] abs_sat(input logic signed [31:0] raw);
    longint v;
    v = raw;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    if (v < 0) begin
      v = -v;
    end
    if (v > 32767) begin
      v = 32767;
    end
    return v[14:0];
  endfunction

  // advance the record by one sample and return the summary it yields
  function automatic result_t fly_summary(input sample_t s);
    result_t            r;
    logic [9:0]         lo;
    logic [9:0]         hi;
    logic [9:0]         d;
    logic [14:0]        a;
    logic signed [31:0] ang [NUM_ANGLES];
    int                 i;
    ang = '{s.roll_centideg, s.pitch_centideg, s.roll_out_milli,
            s.pitch_out_milli, s.yaw_out_milli};
    if (s.armed && !was_armed) begin
      rec_seen         = 1'b1;
      rec_active       = 1'b1;
      rec_start        = s.sample_time_ms;
      rec_end          = s.sample_time_ms;
      rec_stop_flags   = '0;
      rec_disarm_flags = '0;
      rec_batt_min     = BATT_NONE;
      rec_thr_max      = '0;
      rec_motor_max    = '0;
      rec_spread_max   = '0;
      for (i = 0; i < NUM_ANGLES; i++) begin
        rec_peak[i] = '0;
      end
    end
    // armed samples and the disarming one update the record
    if (rec_seen && (s.armed || was_armed)) begin
      lo = clamp_duty(s.motor_duties[15:0]);
      hi = lo;
      for (i = 1; i < MOTORS_DEF; i++) begin
        d = clamp_duty(s.motor_duties[16*i +: 16]);
        if (d < lo) begin
          lo = d;
        end
        if (d > hi) begin
          hi = d;
        end
      end
      rec_end          = s.sample_time_ms;
      rec_stop_flags   = s.fs_flag_word;
      rec_disarm_flags = s.disarm_reason_flags;
      if (s.battery_mv != 16'd0 && s.battery_mv < rec_batt_min) begin
        rec_batt_min = s.battery_mv;
      end
      if (s.throttle_cmd > rec_thr_max) begin
        rec_thr_max = s.throttle_cmd;
      end
      if (hi > rec_motor_max) begin
        rec_motor_max = hi;
      end
      if (hi - lo > rec_spread_max) begin
        rec_spread_max = hi - lo;
      end
      for (i = 0; i < NUM_ANGLES; i++) begin
        a = abs_sat(ang[i]);
        if (a > rec_peak[i]) begin
          rec_peak[i] = a;
        end
      end
    end
    if (!s.armed && was_armed) begin
      rec_active       = 1'b0;
      rec_end          = s.sample_time_ms;
      rec_stop_flags   = s.fs_flag_word;
      rec_disarm_flags = s.disarm_reason_flags;
    end
    was_armed = s.armed;

    r.flight_state = !rec_seen ? FLIGHT_NONE : (rec_active ? FLIGHT_ACTIVE : FLIGHT_ENDED);
    r.flight_len_ms = (rec_end >= rec_start) ? rec_end - rec_start : 32'd0;
    r.stop_and_disarm_flags = {rec_stop_flags, rec_disarm_flags};
    r.min_battery_mv = (rec_batt_min == BATT_NONE) ? 16'd0 : rec_batt_min;
    r.peak_throttle = rec_thr_max;
    r.peak_motor = rec_motor_max;
    r.peak_motor_spread = rec_spread_max;
    r.peak_roll = rec_peak[0];
    r.peak_pitch = rec_peak[1];
    r.peak_roll_out = rec_peak[2];
    r.peak_pitch_out = rec_peak[3];
    r.peak_yaw_out = rec_peak[4];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= REPORT_MAX) begin
        $display("%0t: summary mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    sample_t smp;
    if (!rst_n) begin
      expected_summaries.delete();
      errs             = 0;
      rec_seen         = 1'b0;
      rec_active       = 1'b0;
      was_armed        = 1'b0;
      rec_start        = '0;
      rec_end          = '0;
      rec_stop_flags   = '0;
      rec_disarm_flags = '0;
      rec_batt_min     = '0;
      rec_thr_max      = '0;
      rec_motor_max    = '0;
      rec_spread_max   = '0;
      for (int i = 0; i < NUM_ANGLES; i++) begin
        rec_peak[i] = '0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_FIELDS_W-1:0];
        if (expected_summaries.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX) begin
            $display("%0t: summary request with none outstanding: %h", $time, got);
          end
        end else begin
          want = expected_summaries.pop_front();
          check_field("flight_state", want.flight_state, got.flight_state);
          check_field("flight_len_ms", want.flight_len_ms, got.flight_len_ms);
          check_field("stop_and_disarm_flags", want.stop_and_disarm_flags,
                      got.stop_and_disarm_flags);
          check_field("min_battery_mv", want.min_battery_mv, got.min_battery_mv);
          check_field("peak_throttle", want.peak_throttle, got.peak_throttle);
          check_field("peak_motor", want.peak_motor, got.peak_motor);
          check_field("peak_motor_spread", want.peak_motor_spread, got.peak_motor_spread);
          check_field("peak_roll", want.peak_roll, got.peak_roll);
          check_field("peak_pitch", want.peak_pitch, got.peak_pitch);
          check_field("peak_roll_out", want.peak_roll_out, got.peak_roll_out);
          check_field("peak_pitch_out", want.peak_pitch_out, got.peak_pitch_out);
          check_field("peak_yaw_out", want.peak_yaw_out, got.peak_yaw_out);
        end
      end
      if (in_tvalid && in_tready) begin
        smp = in_tdata[IN_FIELDS_W-1:0];
        expected_summaries.push_back(fly_summary(smp));
      end
    end
    mismatch_count <= errs;
    summaries_due  <= expected_summaries.size();
  end

endmodule

### verif/flight_envelope_statistics_tb.sv
`timescale 1ns / 1ps
// Top of the flight_envelope_statistics testbench: clock, reset, sample stimulus,
// result back-pressure, watchdog and verdict. Uses fes_pkg and fes_summary_checker.
module flight_envelope_statistics_tb;
  import fes_pkg::*;

  localparam int ITEMS      = 1700;  // at least this many samples, directed part included
  localparam int LONG_HOLD  = 300;   // cycles of the one long result stall
  localparam int HOLD_AFTER = 600;   // samples sent before that stall starts
  localparam int IDLE_LIMIT = 2000;  // cycles without any request before giving up
  localparam int DRAIN_WAIT = 8;     // cycles waited once no summary is left due

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;    // sample_t from bit 0, zero pad on top
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // result_t from bit 0, zero pad on top
  logic                   out_tvalid;
  logic                   out_tready;

  int mismatch_count;
  int summaries_due;
  int samples_sent;
  int burst_left;
  int idle_cycles;

  flight_envelope_statistics u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  fes_summary_checker u_summary_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .mismatch_count (mismatch_count),
    .summaries_due  (summaries_due)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --- random field content ---

  // mostly legal duties, some negative, some above full scale, some raw noise
  function automatic logic [15:0] pick_duty();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'h8000 | 16'($urandom_range(0, 32767));
      1:       v = 16'($urandom_range(1001, 32767));
      2:       v = 16'($urandom);
      3:       v = 16'd1000;
      default: v = 16'($urandom_range(0, 1000));
    endcase
    return v;
  endfunction

  // mostly small magnitudes, some clustered round the 16-bit clamp, plus full-range words
  function automatic logic [31:0] pick_angle();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       mag = $urandom_range(32760, 32775);
      2:       mag = $urandom_range(0, 18000);
      default: mag = $urandom_range(0, 4000);
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic sample_t make_sample(input logic armed, input logic [31:0] t);
    sample_t s;
    int      m;
    s.armed = armed;
    s.sample_time_ms = t;
    s.fs_flag_word = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    s.disarm_reason_flags = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    s.throttle_cmd = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 1000));
    case ($urandom_range(0, 11))
      0:       s.battery_mv = 16'd0;       // invalid reading
      1:       s.battery_mv = 16'hFFFF;
      2:       s.battery_mv = 16'($urandom);
      default: s.battery_mv = 16'($urandom_range(9000, 25200));
    endcase
    for (m = 0; m < 4; m++) begin
      s.motor_duties[16*m +: 16] = pick_duty();
    end
    s.roll_centideg   = pick_angle();
    s.pitch_centideg  = pick_angle();
    s.roll_out_milli  = pick_angle();
    s.pitch_out_milli = pick_angle();
    s.yaw_out_milli   = pick_angle();
    return s;
  endfunction

  // mostly small forward steps, now and then a jump anywhere (wrap, backwards)
  function automatic logic [31:0] next_time(input logic [31:0] t);
    return ($urandom_range(0, 29) == 0) ? $urandom : t + $urandom_range(0, 50);
  endfunction

  // Offer one sample and hold it until the request is taken. Bursts of random
  // length, then a random gap with tvalid low; long bursts give gap-free stretches.
  task automatic offer_sample(input sample_t s);
    int gap;
    in_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, s};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // --- sample stimulus and verdict ---
  initial begin
    sample_t     s;
    logic [31:0] t;
    int          run_len;
    int          kind;
    int          i;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    samples_sent = 0;
    burst_left   = 4;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any flight: summary stays all zero
    offer_sample(make_sample(1'b0, 32'd100));

    // arming sample with flags, battery, throttle, duties and angles at an extreme
    s = make_sample(1'b1, 32'd1000);
    s.battery_mv          = 16'd0;
    s.throttle_cmd        = 16'hFFFF;
    s.motor_duties        = {16'h8000, 16'h7FFF, 16'd1000, 16'd0};
    s.roll_centideg       = 32'sh8000_0000;
    s.pitch_centideg      = 32'sh7FFF_FFFF;
    s.roll_out_milli      = -32'sd32768;
    s.pitch_out_milli     = 32'sd32767;
    s.yaw_out_milli       = -32'sd32767;
    s.fs_flag_word        = 16'hFFFF;
    s.disarm_reason_flags = 16'hFFFF;
    offer_sample(s);
    // a genuine 65535 mV reading still reads as none; equal duties, no spread
    s = make_sample(1'b1, 32'd1010);
    s.battery_mv      = 16'hFFFF;
    s.motor_duties    = {4{16'd1001}};
    s.roll_centideg   = -32'sd32769;
    s.pitch_centideg  = 32'sd32768;
    s.roll_out_milli  = -32'sd1;
    s.pitch_out_milli = 32'sd1;
    s.yaw_out_milli   = 32'sd0;
    offer_sample(s);
    s = make_sample(1'b1, 32'd1020);
    s.battery_mv   = 16'd1;
    s.motor_duties = {16'd0, 16'd1000, 16'hFFFF, 16'd500};
    offer_sample(s);
    s = make_sample(1'b1, 32'd1030);
    s.battery_mv   = 16'd65534;
    s.throttle_cmd = 16'd0;
    s.fs_flag_word = 16'd0;
    offer_sample(s);
    // disarming sample still updates the record
    s = make_sample(1'b0, 32'd2000);
    s.yaw_out_milli = 32'sd40000;
    offer_sample(s);
    // disarmed samples are ignored, flight stays ended
    s = make_sample(1'b0, 32'd2100);
    s.battery_mv    = 16'd2;
    s.roll_centideg = 32'sh7FFF_FFFF;
    offer_sample(s);
    offer_sample(make_sample(1'b0, 32'd2200));

    // new flight clears the record; time running backwards gives zero duration
    offer_sample(make_sample(1'b1, 32'd5000));
    offer_sample(make_sample(1'b1, 32'd4000));
    offer_sample(make_sample(1'b1, 32'hFFFF_FFFF));
    offer_sample(make_sample(1'b0, 32'd5));

    // full-range duration, battery only ever at 65535
    s = make_sample(1'b1, 32'd0);
    s.battery_mv = 16'hFFFF;
    offer_sample(s);
    s = make_sample(1'b1, 32'hFFFF_FFFF);
    s.battery_mv = 16'hFFFF;
    offer_sample(s);
    s = make_sample(1'b0, 32'hFFFF_FFFF);
    s.battery_mv = 16'hFFFF;
    offer_sample(s);
    offer_sample(make_sample(1'b0, 32'd0));

    // random part: mostly whole flights, some idle stretches and armed-bit noise
    t = 32'd10000;
    while (samples_sent < ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 25);
        for (i = 0; i < run_len; i++) begin
          t = next_time(t);
          offer_sample(make_sample(1'b1, t));
        end
        t = next_time(t);
        offer_sample(make_sample(1'b0, t));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 5)) begin
          t = next_time(t);
          offer_sample(make_sample(1'b0, t));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          t = next_time(t);
          offer_sample(make_sample($urandom_range(0, 1), t));
        end
      end
    end
    in_tvalid <= 1'b0;

    // drain: the count seen here is registered and lags, so look after each edge
    do @(posedge clk); while (summaries_due != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS flight_envelope_statistics");
    end else begin
      $display("FAIL flight_envelope_statistics");
    end
    $finish;
  end

  // --- result back-pressure ---
  // Spans of random length, each with its own stall pattern. Once, after enough
  // samples, tready stays low for a long stretch so the pipe fills and in_tready drops.
  initial begin
    int mode;
    int span;
    int k;
    bit held_once;
    out_tready <= 1'b0;
    held_once  = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        if (!held_once && samples_sent >= HOLD_AFTER) begin
          held_once = 1'b1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) != 0);
          2:       out_tready <= ($urandom_range(0, 6) != 0);
          default: out_tready <= ((k % 5) != 4);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog: too long without a request on either channel means a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL flight_envelope_statistics");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fes_pkg.sv
hw/rtl/fes_sample_conv.sv
hw/rtl/fes_record.sv
hw/rtl/flight_envelope_statistics.sv
hw/rtl/fes_checker.sv
verif/fes_summary_checker.sv
verif/flight_envelope_statistics_tb.sv
